### rtl/mid_pkg.sv
// Package for the MIPS instruction decoder: mnemonic tables and GTE patterns.
// Depends on nothing; used by mid_classify and mips_instruction_decoder.
package mid_pkg;

    localparam int unsigned MnemWidth = 8;
    typedef logic [MnemWidth-1:0] t_mnem;

    localparam logic [5:0] OpSpecial = 6'd0;
    localparam logic [5:0] OpRegimm  = 6'd1;
    localparam logic [5:0] OpBeq     = 6'd4;
    localparam logic [5:0] OpBne     = 6'd5;
    localparam logic [5:0] OpAddiu   = 6'd9;
    localparam logic [5:0] OpCop0    = 6'd16;
    localparam logic [5:0] OpCop2    = 6'd18;
    localparam logic [5:0] FnAddu    = 6'h21;

    localparam logic [24:0] GteMask = 25'h1f003ff;

    localparam t_mnem MnUnknown = 8'd0;
    localparam t_mnem MnNop     = 8'd1;
    localparam t_mnem MnMove    = 8'd27;
    localparam t_mnem MnBeqz    = 8'd58;
    localparam t_mnem MnBeq     = 8'd59;
    localparam t_mnem MnBnez    = 8'd60;
    localparam t_mnem MnBne     = 8'd61;
    localparam t_mnem MnLi      = 8'd65;
    localparam t_mnem MnAddiu   = 8'd66;
    localparam t_mnem MnMfc0    = 8'd73;
    localparam t_mnem MnCfc0    = 8'd74;
    localparam t_mnem MnMtc0    = 8'd75;
    localparam t_mnem MnRfe     = 8'd76;
    localparam t_mnem MnCop2    = 8'd99;
    localparam t_mnem MnMfc2    = 8'd100;
    localparam t_mnem MnCfc2    = 8'd101;
    localparam t_mnem MnMtc2    = 8'd102;
    localparam t_mnem MnCtc2    = 8'd103;

    localparam t_mnem SpecialIds [64] = '{
        8'd2, 8'd0, 8'd3, 8'd4, 8'd5, 8'd0, 8'd6, 8'd7,
        8'd8, 8'd9, 8'd0, 8'd0, 8'd10, 8'd11, 8'd0, 8'd12,
        8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd0, 8'd18, 8'd19,
        8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd0, 8'd0, 8'd25,
        8'd26, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34,
        8'd0, 8'd0, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40,
        8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd0, 8'd46, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam t_mnem RegimmIds [32] = '{
        8'd47, 8'd48, 8'd49, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd51, 8'd52, 8'd0, 8'd53, 8'd54, 8'd0, 8'd55, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam t_mnem OpcodeIds [64] = '{
        8'd0, 8'd0, 8'd56, 8'd57, 8'd59, 8'd61, 8'd62, 8'd63,
        8'd64, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd104, 8'd105, 8'd106, 8'd107,
        8'd108, 8'd109, 8'd110, 8'd111, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
        8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd0,
        8'd127, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134,
        8'd135, 8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142
    };

    localparam logic [24:0] GteMaskedPat [5] = '{
        25'h0400012, 25'h0a00428, 25'h170000c, 25'h190003d, 25'h1a0003e
    };
    localparam t_mnem GteMaskedId [5] = '{8'd77, 8'd78, 8'd79, 8'd80, 8'd81};

    localparam logic [24:0] GteExactPat [17] = '{
        25'h0180001, 25'h0280030, 25'h0680029, 25'h0780010, 25'h0980011,
        25'h0c8041e, 25'h0d80420, 25'h0e80413, 25'h0f80416, 25'h0f8002a,
        25'h108041b, 25'h118043f, 25'h1280414, 25'h138041c, 25'h1400006,
        25'h158002d, 25'h168002e
    };
    localparam t_mnem GteExactId [17] = '{
        8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90,
        8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd96, 8'd97, 8'd98
    };

endpackage

### rtl/mid_classify.sv
// Combinational mnemonic classifier for one 32-bit MIPS instruction word.
// Depends on mid_pkg for the opcode, funct, regimm and GTE tables.
module mid_classify import mid_pkg::*; (
    input  logic [31:0] i_word,
    output t_mnem       o_mnem
);

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [5:0]  fn;
    logic [24:0] cmd;
    t_mnem       gte_id;

    assign op  = i_word[31:26];
    assign rs  = i_word[25:21];
    assign rt  = i_word[20:16];
    assign fn  = i_word[5:0];
    assign cmd = i_word[24:0];

    // Masked patterns take priority over exact codes, earliest entry first.
    always_comb begin
        gte_id = MnCop2;
        for (int i = 16; i >= 0; i--) begin
            if (cmd == GteExactPat[i]) begin
                gte_id = GteExactId[i];
            end
        end
        for (int i = 4; i >= 0; i--) begin
            if ((cmd & GteMask) == GteMaskedPat[i]) begin
                gte_id = GteMaskedId[i];
            end
        end
    end

    always_comb begin
        unique case (op)
            OpSpecial: begin
                if (i_word == '0) begin
                    o_mnem = MnNop;
                end else if (fn == FnAddu && rt == 5'd0) begin
                    o_mnem = MnMove;
                end else begin
                    o_mnem = SpecialIds[fn];
                end
            end
            OpRegimm: o_mnem = RegimmIds[rt];
            OpBeq:    o_mnem = (rt == 5'd0) ? MnBeqz : MnBeq;
            OpBne:    o_mnem = (rt == 5'd0) ? MnBnez : MnBne;
            OpAddiu:  o_mnem = (rs == 5'd0) ? MnLi : MnAddiu;
            OpCop0: begin
                unique case (rs)
                    5'd0:    o_mnem = MnMfc0;
                    5'd1:    o_mnem = MnCfc0;
                    5'd4:    o_mnem = MnMtc0;
                    5'd16:   o_mnem = (i_word[4:0] == 5'd16) ? MnRfe : MnUnknown;
                    default: o_mnem = MnUnknown;
                endcase
            end
            OpCop2: begin
                if (i_word[25]) begin
                    o_mnem = gte_id;
                end else begin
                    unique case (rs)
                        5'd0:    o_mnem = MnMfc2;
                        5'd2:    o_mnem = MnCfc2;
                        5'd4:    o_mnem = MnMtc2;
                        5'd6:    o_mnem = MnCtc2;
                        default: o_mnem = MnUnknown;
                    endcase
                end
            end
            default:  o_mnem = OpcodeIds[op];
        endcase
    end

endmodule

### rtl/mips_instruction_decoder.sv
// MIPS instruction decoder top level: input register, classifier, result register.
// Depends on mid_pkg and mid_classify.
// One word per cycle, unless i_stall holds a full result register.
// The input stage refills whenever the result register is free or being drained.
// Reset clears both valid flags and the address counter to zero.
module mips_instruction_decoder import mid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_instr_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_word_address,
    output logic [7:0]         o_mnemonic_id,
    output logic [4:0]         o_dest_reg,
    output logic [4:0]         o_src_reg,
    output logic [4:0]         o_target_reg,
    output logic [4:0]         o_shift_amount,
    output logic signed [15:0] o_immediate,
    output logic signed [17:0] o_branch_offset,
    output logic [27:0]        o_jump_target,
    output logic [19:0]        o_trap_code,
    output logic [24:0]        o_gte_command
);

    logic        r_in_valid;
    logic [31:0] r_word;
    logic [31:0] r_addr;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [31:0] r_out_addr;
    t_mnem       r_out_mnem;
    t_mnem       n_mnem;
    logic        out_free;
    logic        in_take;
    logic        mid_move;

    assign out_free = !r_out_valid || !i_stall;
    assign mid_move = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    mid_classify u_classify (
        .i_word(r_word),
        .o_mnem(n_mnem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_addr     <= r_addr + 32'd4;
            end else if (mid_move) begin
                r_in_valid <= 1'b0;
            end
            if (mid_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_instr_word;
        end
        if (mid_move) begin
            r_out_word <= r_word;
            r_out_mnem <= n_mnem;
            r_out_addr <= r_addr - 32'd4;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_word_address  = r_out_addr;
    assign o_mnemonic_id   = r_out_mnem;
    assign o_dest_reg      = r_out_word[15:11];
    assign o_src_reg       = r_out_word[25:21];
    assign o_target_reg    = r_out_word[20:16];
    assign o_shift_amount  = r_out_word[10:6];
    assign o_immediate     = r_out_word[15:0];
    assign o_branch_offset = {r_out_word[15:0], 2'b00};
    assign o_jump_target   = {r_out_word[25:0], 2'b00};
    assign o_trap_code     = r_out_word[25:6];
    assign o_gte_command   = r_out_word[24:0];

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a full pipeline");
    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_addr == $past(r_addr) + 32'd4))
        else $error("address counter did not advance by four");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_out_addr)))
        else $error("stalled result changed");

endmodule

### sim/tb_top.sv
// Testbench for mips_instruction_decoder: directed table then random words,
// checked against an in-bench classifier. Depends on mid_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import mid_pkg::*;

    localparam int unsigned NumRandom = 1800;
    localparam int unsigned IdleLimit = 2000;

    typedef struct packed {
        logic [31:0] word_address;
        logic [7:0]  mnemonic_id;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg;
        logic [4:0]  target_reg;
        logic [4:0]  shift_amount;
        logic [15:0] immediate;
        logic [17:0] branch_offset;
        logic [27:0] jump_target;
        logic [19:0] trap_code;
        logic [24:0] gte_command;
    } t_decoded;

    typedef struct {
        logic [31:0] word;
        logic        has_mnem;
        t_mnem       mnem;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instr_word;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_word_address;
    logic [7:0]  o_mnemonic_id;
    logic [4:0]  o_dest_reg;
    logic [4:0]  o_src_reg;
    logic [4:0]  o_target_reg;
    logic [4:0]  o_shift_amount;
    logic signed [15:0] o_immediate;
    logic signed [17:0] o_branch_offset;
    logic [27:0] o_jump_target;
    logic [19:0] o_trap_code;
    logic [24:0] o_gte_command;

    t_decoded    pending_decodes [$];
    logic [31:0] next_address;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned idle_cycles;
    bit          failed;

    mips_instruction_decoder dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_mnem gte_mnemonic(logic [31:0] w);
        logic [24:0] c;
        c = w[24:0];
        for (int i = 0; i < 5; i++) begin
            if ((c & GteMask) == GteMaskedPat[i]) return GteMaskedId[i];
        end
        for (int i = 0; i < 17; i++) begin
            if (c == GteExactPat[i]) return GteExactId[i];
        end
        return MnCop2;
    endfunction

    function automatic t_mnem mnemonic_of(logic [31:0] w);
        logic [5:0] op;
        logic [4:0] rs;
        logic [4:0] rt;
        op = w[31:26];
        rs = w[25:21];
        rt = w[20:16];
        case (op)
            OpSpecial: begin
                if (w == 32'd0) return MnNop;
                if (w[5:0] == FnAddu && rt == 5'd0) return MnMove;
                return SpecialIds[w[5:0]];
            end
            OpRegimm: return RegimmIds[rt];
            OpBeq:    return (rt == 5'd0) ? MnBeqz : MnBeq;
            OpBne:    return (rt == 5'd0) ? MnBnez : MnBne;
            OpAddiu:  return (rs == 5'd0) ? MnLi : MnAddiu;
            OpCop0: begin
                if (rs == 5'd0) return MnMfc0;
                if (rs == 5'd1) return MnCfc0;
                if (rs == 5'd4) return MnMtc0;
                if (rs == 5'd16) return (w[4:0] == 5'd16) ? MnRfe : MnUnknown;
                return MnUnknown;
            end
            OpCop2: begin
                if (w[25]) return gte_mnemonic(w);
                if (rs == 5'd0) return MnMfc2;
                if (rs == 5'd2) return MnCfc2;
                if (rs == 5'd4) return MnMtc2;
                if (rs == 5'd6) return MnCtc2;
                return MnUnknown;
            end
            default: return OpcodeIds[op];
        endcase
    endfunction

    function automatic t_decoded decode_word(logic [31:0] w, logic [31:0] addr);
        t_decoded d;
        d.word_address  = addr;
        d.mnemonic_id   = mnemonic_of(w);
        d.dest_reg      = w[15:11];
        d.src_reg       = w[25:21];
        d.target_reg    = w[20:16];
        d.shift_amount  = w[10:6];
        d.immediate     = w[15:0];
        d.branch_offset = {w[15:0], 2'b00};
        d.jump_target   = {w[25:0], 2'b00};
        d.trap_code     = w[25:6];
        d.gte_command   = w[24:0];
        return d;
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int unsigned kind;
        w = $urandom();
        kind = $urandom_range(0, 9);
        case (kind)
            0: w[31:26] = OpSpecial;
            1: w[31:26] = OpRegimm;
            2: begin
                w[31:25] = {OpCop2, 1'b1};
                if ($urandom_range(0, 1)) begin
                    w[24:0] = GteExactPat[$urandom_range(0, 16)];
                end else begin
                    w[24:0] = (w[24:0] & ~GteMask) | GteMaskedPat[$urandom_range(0, 4)];
                end
            end
            3: w[31:26] = $urandom_range(0, 1) ? OpCop0 : OpCop2;
            4: begin
                w[31:26] = 6'($urandom_range(0, 9));
                if ($urandom_range(0, 1)) w[25:16] = '0;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(logic [31:0] w, logic has_mnem, t_mnem mnem);
        t_decoded d;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_instr_word <= w;
        d = decode_word(w, next_address);
        if (has_mnem && d.mnemonic_id != mnem) begin
            $error("table row %h: mnemonic_id expected %0d, predicted %0d",
                   w, mnem, d.mnemonic_id);
            failed = 1'b1;
        end
        pending_decodes.push_back(d);
        next_address = next_address + 32'd4;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_decoded e;
        t_decoded a;
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            a = '{o_word_address, o_mnemonic_id, o_dest_reg, o_src_reg, o_target_reg,
                  o_shift_amount, o_immediate, o_branch_offset, o_jump_target,
                  o_trap_code, o_gte_command};
            if (pending_decodes.size() == 0) begin
                $error("result transfer with nothing expected");
                failed = 1'b1;
            end else begin
                e = pending_decodes.pop_front();
                if (a.word_address != e.word_address) begin
                    $error("word_address expected %h got %h", e.word_address, a.word_address);
                    failed = 1'b1;
                end
                if (a.mnemonic_id != e.mnemonic_id) begin
                    $error("mnemonic_id expected %0d got %0d", e.mnemonic_id, a.mnemonic_id);
                    failed = 1'b1;
                end
                if (a.dest_reg != e.dest_reg) begin
                    $error("dest_reg expected %0d got %0d", e.dest_reg, a.dest_reg);
                    failed = 1'b1;
                end
                if (a.src_reg != e.src_reg) begin
                    $error("src_reg expected %0d got %0d", e.src_reg, a.src_reg);
                    failed = 1'b1;
                end
                if (a.target_reg != e.target_reg) begin
                    $error("target_reg expected %0d got %0d", e.target_reg, a.target_reg);
                    failed = 1'b1;
                end
                if (a.shift_amount != e.shift_amount) begin
                    $error("shift_amount expected %0d got %0d",
                           e.shift_amount, a.shift_amount);
                    failed = 1'b1;
                end
                if (a.immediate != e.immediate) begin
                    $error("immediate expected %h got %h", e.immediate, a.immediate);
                    failed = 1'b1;
                end
                if (a.branch_offset != e.branch_offset) begin
                    $error("branch_offset expected %h got %h",
                           e.branch_offset, a.branch_offset);
                    failed = 1'b1;
                end
                if (a.jump_target != e.jump_target) begin
                    $error("jump_target expected %h got %h", e.jump_target, a.jump_target);
                    failed = 1'b1;
                end
                if (a.trap_code != e.trap_code) begin
                    $error("trap_code expected %h got %h", e.trap_code, a.trap_code);
                    failed = 1'b1;
                end
                if (a.gte_command != e.gte_command) begin
                    $error("gte_command expected %h got %h", e.gte_command, a.gte_command);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        t_row rows [$];
        int unsigned phase;
        // Special cases: nop, the pseudo-forms, ori with a negative immediate,
        // rfe and its near miss, GTE patterns, and unlisted selectors.
        rows = '{
            '{32'h0000_0000, 1'b1, MnNop},
            '{32'hffff_ffff, 1'b1, t_mnem'(142)},
            '{32'h0000_0040, 1'b1, t_mnem'(2)},
            '{32'h0080_1021, 1'b1, MnMove},
            '{32'h0085_1021, 1'b0, MnUnknown},
            '{32'h2404_8000, 1'b1, MnLi},
            '{32'h2484_7fff, 1'b1, MnAddiu},
            '{32'h1080_ffff, 1'b1, MnBeqz},
            '{32'h1085_0001, 1'b1, MnBeq},
            '{32'h1480_8000, 1'b1, MnBnez},
            '{32'h1485_7fff, 1'b1, MnBne},
            '{32'h3484_8000, 1'b1, t_mnem'(70)},
            '{32'h4200_0010, 1'b1, MnRfe},
            '{32'h4200_0011, 1'b1, MnUnknown},
            '{32'h4000_0000, 1'b1, MnMfc0},
            '{32'h4a40_0012, 1'b1, t_mnem'(77)},
            '{32'h4a18_0001, 1'b1, t_mnem'(82)},
            '{32'h4a00_0000, 1'b1, MnCop2},
            '{32'h48c0_0000, 1'b1, MnCtc2},
            '{32'h4820_0000, 1'b1, MnUnknown},
            '{32'h0000_0001, 1'b1, MnUnknown},
            '{32'h0410_0000, 1'b1, MnUnknown},
            '{32'h0fff_ffff, 1'b1, t_mnem'(57)},
            '{32'hbc00_0000, 1'b1, MnUnknown},
            '{32'h03ff_ffcd, 1'b0, MnUnknown}
        };
        failed         = 1'b0;
        next_address   = 32'd0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_stall      <= 1'b0;
        i_instr_word <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send_word(rows[i].word, rows[i].has_mnem, rows[i].mnem);
        for (int n = 0; n < NumRandom; n++) begin
            phase = (n * 5) / NumRandom;
            send_idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 18 : 0;
            recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 18 : 0;
            send_word(random_word(), 1'b0, MnUnknown);
        end
        i_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
